/* hdl/calendar_date_difference_defines.svh */
// Assertion macros used by the merge stage of the date difference RTL.
`ifndef CALENDAR_DATE_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define CDD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("date difference check failed");

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define CDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("date difference sequencing check failed");

`endif

/* hdl/cdd_pkg.sv */
// Shared widths, constants, tables and types of the date difference block.
`timescale 1ns / 1ps
`default_nettype none

package cdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 23;
  localparam int DIFF_W  = 22;

  // Largest accepted year, compared at a width that holds any year limit.
  localparam int MAX_YEAR = 9999;
  localparam logic [16:0] MAX_YEAR_C = 17'(MAX_YEAR);

  localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

  // 5243 / 2^17 is close enough to 1/25 for every 12-bit dividend.
  localparam logic [12:0] RECIP25 = 13'd5243;
  localparam int RECIP25_SHIFT = 17;

  // Result of one lane: day count since 0001-01-01 and date check.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               ok;
  } lane_res_t;

  function automatic logic [24:0] recip25_mul(input logic [11:0] x);
    recip25_mul = 25'(x) * 25'(RECIP25);
  endfunction

  function automatic logic [11:0] mul25(input logic [7:0] q);
    mul25 = 12'({q, 4'b0000}) + 12'({q, 3'b000}) + 12'(q);
  endfunction

  // Length of a month in a common year; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:                                       month_len = 5'd28;
      default:                                    month_len = 5'd0;
    endcase
  endfunction

  // Days of the months before month m in a common year.
  function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    cum_days = 9'd0;
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hdl/cdd_lane.sv */
// One date lane: checks a date and turns it into a day count over three stages.
`timescale 1ns / 1ps
`default_nettype none

module cdd_lane
  import cdd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [DAY_W-1:0]   day_i,
  input  wire logic [MONTH_W-1:0] month_i,
  input  wire logic [YEAR_W-1:0]  year_i,
  output lane_res_t               res_o
);

  // Stage 1: the date and the reciprocal products for year/4/25 and year/16/25.
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [YEAR_W-1:0]  year_q;
  logic [24:0]        prod_a_q, prod_b_q;

  always_ff @(posedge clk_i) begin
    day_q    <= day_i;
    month_q  <= month_i;
    year_q   <= year_i;
    prod_a_q <= recip25_mul(year_i[YEAR_W-1:2]);
    prod_b_q <= recip25_mul({2'b00, year_i[YEAR_W-1:4]});
  end

  // Stage 2: leap rule, date check and the three parts of the count.
  logic [11:0]        quarter, sixteenth;
  logic [7:0]         qa, qb;
  logic               div100, div400, leap;
  logic [4:0]         dim;
  logic               ok_d;
  logic [YEAR_W-1:0]  prev_year;
  logic [7:0]         prev100, prev400;
  logic [12:0]        frac_d;
  logic [8:0]         part_d;
  logic [COUNT_W-1:0] y365_d;

  always_comb begin
    quarter   = year_q[YEAR_W-1:2];
    sixteenth = {2'b00, year_q[YEAR_W-1:4]};
    qa        = prod_a_q[24:RECIP25_SHIFT];
    qb        = prod_b_q[24:RECIP25_SHIFT];
    div100    = (year_q[1:0] == 2'b00) && (quarter == mul25(qa));
    div400    = (year_q[3:0] == 4'b0000) && (sixteenth == mul25(qb));
    leap      = ((year_q[1:0] == 2'b00) && !div100) || div400;

    dim = (month_q == MONTH_FEB) ? (leap ? 5'd29 : 5'd28) : month_len(month_q);
    ok_d = (year_q != '0) && ({3'b000, year_q} <= MAX_YEAR_C) &&
           (month_q inside {[4'd1:4'd12]}) &&
           (day_q != '0) && (day_q <= dim);

    // Earlier years in closed form; the corrections turn year/100 and
    // year/400 into (year-1)/100 and (year-1)/400.
    prev_year = year_q - 14'd1;
    prev100   = qa - 8'(div100);
    prev400   = qb - 8'(div400);
    frac_d    = 13'(prev_year[YEAR_W-1:2]) - 13'(prev100) + 13'(prev400);
    y365_d    = 23'(prev_year) * 23'd365;

    part_d = cum_days(month_q) + 9'(leap && (month_q > MONTH_FEB)) + 9'(day_q);
  end

  logic [COUNT_W-1:0] y365_q;
  logic [12:0]        frac_q;
  logic [8:0]         part_q;
  logic               ok_q;

  always_ff @(posedge clk_i) begin
    y365_q <= y365_d;
    frac_q <= frac_d;
    part_q <= part_d;
    ok_q   <= ok_d;
  end

  // Stage 3: final sum of the day count.
  lane_res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.count <= y365_q + 23'(frac_q) + 23'(part_q);
    res_q.ok    <= ok_q;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* hdl/cdd_merge.sv */
// Merge stage: absolute difference of the two lane counts and the result strobe.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_date_difference_defines.svh"

module cdd_merge
  import cdd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire lane_res_t         lane_a_i,
  input  wire lane_res_t         lane_b_i,
  output logic                   done_o,
  output logic [DIFF_W-1:0]      day_difference_o,
  output logic                   dates_valid_o
);

  logic [COUNT_W-1:0] diff;
  logic               both_ok;
  logic [DIFF_W-1:0]  diff_d;

  always_comb begin
    diff = (lane_a_i.count >= lane_b_i.count) ? (lane_a_i.count - lane_b_i.count)
                                              : (lane_b_i.count - lane_a_i.count);
    both_ok = lane_a_i.ok && lane_b_i.ok;
    if (!both_ok) begin
      diff_d = '0;
    end else if (diff > COUNT_W'(DIFF_MAX)) begin
      diff_d = DIFF_MAX;
    end else begin
      diff_d = diff[DIFF_W-1:0];
    end
  end

  logic              done_q;
  logic [DIFF_W-1:0] diff_q;
  logic              ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    ok_q   <= both_ok;
  end

  assign done_o           = done_q;
  assign day_difference_o = diff_q;
  assign dates_valid_o    = ok_q;

  `CDD_ASSERT_NXT(a_strobe_follows, valid_i, done_o)
  `CDD_ASSERT_NXT(a_no_spurious_strobe, !valid_i, !done_o)
  `CDD_ASSERT_IMP(a_invalid_is_zero, done_o && !dates_valid_o, day_difference_o == '0)
  `CDD_ASSERT_NXT(a_bad_lane_flags, valid_i && !(lane_a_i.ok && lane_b_i.ok), !dates_valid_o)

endmodule

`default_nettype wire

/* hdl/calendar_date_difference.sv */
// Top level of the Gregorian date difference block: two date lanes and a merge stage.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A word of two dates (day, month, year each) is taken at a rising clock
//   edge where start_i is high and busy_o is low. busy_o is always low, so a
//   new word may be started in every cycle.
//   Each date runs through its own lane, which checks it and forms its day
//   count since 0001-01-01 in three stages: reciprocal products for the
//   divisions by 100 and 400, then the leap rule, date check and the parts
//   of the count, then the final sum. A merge stage forms the absolute
//   difference, saturates it and zeroes it for an invalid date.
//   The result word appears on day_difference_o and dates_valid_o once the
//   word has passed the three lane stages and the merge register, marked by
//   done_o, and stays for exactly one cycle, at whose end the receiver takes it.
//   Throughput is one word per cycle; the pipeline has no stall path since
//   the receiver cannot hold results off and must take each word as shown.
//   Reset clears the stage valid bits, so no done_o pulse follows reset
//   until a word is started; payload registers are not reset.

module calendar_date_difference
  import cdd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [DAY_W-1:0]   first_day_i,
  input  wire logic [MONTH_W-1:0] first_month_i,
  input  wire logic [YEAR_W-1:0]  first_year_i,
  input  wire logic [DAY_W-1:0]   second_day_i,
  input  wire logic [MONTH_W-1:0] second_month_i,
  input  wire logic [YEAR_W-1:0]  second_year_i,
  output logic                    done_o,
  output logic [DIFF_W-1:0]       day_difference_o,
  output logic                    dates_valid_o
);

  // The pipeline never stalls, so a word can be started in every cycle.
  assign busy_o = 1'b0;

  // Valid bits that travel alongside the three lane stages.
  logic [2:0] valid_q, valid_d;

  always_comb begin
    valid_d = {valid_q[1:0], start_i && !busy_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  lane_res_t lane_a, lane_b;

  cdd_lane u_lane_a (
    .clk_i   (clk_i),
    .day_i   (first_day_i),
    .month_i (first_month_i),
    .year_i  (first_year_i),
    .res_o   (lane_a)
  );

  cdd_lane u_lane_b (
    .clk_i   (clk_i),
    .day_i   (second_day_i),
    .month_i (second_month_i),
    .year_i  (second_year_i),
    .res_o   (lane_b)
  );

  cdd_merge u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_q[2]),
    .lane_a_i         (lane_a),
    .lane_b_i         (lane_b),
    .done_o           (done_o),
    .day_difference_o (day_difference_o),
    .dates_valid_o    (dates_valid_o)
  );

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the calendar_date_difference block.
`timescale 1ns / 1ps

module tb;
  import cdd_pkg::*;

  // Largest day difference the result field can carry; larger ones saturate.
  localparam int unsigned DIFF_LIMIT = (1 << DIFF_W) - 1;

  // Number of random words after the directed table.
  localparam int RANDOM_WORDS = 1025;

  // Words at the end of the run that are sent back to back, without gaps.
  localparam int TAIL_WORDS = 150;

  // One result word: the day difference and the validity flag.
  typedef struct {
    logic [DIFF_W-1:0] diff;
    logic              valid;
  } date_result_t;

  // One input word, with an optional expected result typed in by hand.
  typedef struct {
    logic [DAY_W-1:0]   d1;
    logic [MONTH_W-1:0] m1;
    logic [YEAR_W-1:0]  y1;
    logic [DAY_W-1:0]   d2;
    logic [MONTH_W-1:0] m2;
    logic [YEAR_W-1:0]  y2;
    bit                 typed;
    date_result_t       result;
  } date_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [DAY_W-1:0]   first_day_i;
  logic [MONTH_W-1:0] first_month_i;
  logic [YEAR_W-1:0]  first_year_i;
  logic [DAY_W-1:0]   second_day_i;
  logic [MONTH_W-1:0] second_month_i;
  logic [YEAR_W-1:0]  second_year_i;
  logic               done_o;
  logic [DIFF_W-1:0]  day_difference_o;
  logic               dates_valid_o;

  // The hand-typed expectation travels with the word it belongs to, so the
  // monitor sees it at the same edge at which the word is accepted.
  bit                 word_typed_q;
  date_result_t       word_result_q;

  // Expected results of accepted words, oldest first.
  date_result_t       pending_results[$];
  date_word_t         directed_words[$];
  int                 error_count;

  calendar_date_difference i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .first_day_i     (first_day_i),
    .first_month_i   (first_month_i),
    .first_year_i    (first_year_i),
    .second_day_i    (second_day_i),
    .second_month_i  (second_month_i),
    .second_year_i   (second_year_i),
    .done_o          (done_o),
    .day_difference_o(day_difference_o),
    .dates_valid_o   (dates_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The run is far shorter than this; reaching it means the block hung.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor of the block, built from the calendar rules.
  // ---------------------------------------------------------------------

  // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Length of month m of year y; zero for a code that is no month.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_is_valid(input int unsigned d, input int unsigned m,
                                       input int unsigned y);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Day number of a valid date, 0001-01-01 being day 1. Earlier years are
  // counted in closed form, earlier months of the same year one by one.
  function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < m; k++) n += month_days(k, y);
    return n + d;
  endfunction

  function automatic date_result_t predict_day_difference(
      input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1, input logic [YEAR_W-1:0] y1,
      input logic [DAY_W-1:0] d2, input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
    date_result_t r;
    int unsigned  a;
    int unsigned  b;
    int unsigned  diff;
    r.diff  = '0;
    r.valid = 1'b0;
    if (date_is_valid(d1, m1, y1) && date_is_valid(d2, m2, y2)) begin
      a    = day_number(d1, m1, y1);
      b    = day_number(d2, m2, y2);
      diff = (a > b) ? a - b : b - a;
      if (diff > DIFF_LIMIT) diff = DIFF_LIMIT;
      r.diff  = DIFF_W'(diff);
      r.valid = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: records accepted words and checks every result strobe.
  // ---------------------------------------------------------------------

  // Inputs and outputs are read here before the edge takes effect, so a word
  // counts as accepted when start_i was high and busy_o low in the cycle
  // that this edge ends, and a result is the one shown during that cycle.
  always @(posedge clk_i) begin
    date_result_t got;
    date_result_t want;
    if (rst_ni) begin
      if ($isunknown(done_o)) begin
        error_count++;
        if (error_count <= 10) $display("ERROR: done_o is unknown at %0t", $realtime);
      end else if (done_o) begin
        got.diff  = day_difference_o;
        got.valid = dates_valid_o;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: result diff=%0d valid=%0b with no word outstanding",
                     got.diff, got.valid);
        end else begin
          want = pending_results.pop_front();
          if (got.diff !== want.diff || got.valid !== want.valid) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: expected diff=%0d valid=%0b, got diff=%0d valid=%0b",
                       want.diff, want.valid, got.diff, got.valid);
          end
        end
      end

      if (start_i && !busy_o) begin
        if (word_typed_q) begin
          pending_results.push_back(word_result_q);
        end else begin
          pending_results.push_back(predict_day_difference(
              first_day_i, first_month_i, first_year_i,
              second_day_i, second_month_i, second_year_i));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------

  // Adds one row to the directed table. A row with typed set carries its own
  // expected result; the others are checked against the predictor.
  task automatic add_row(input int d1, input int m1, input int y1,
                         input int d2, input int m2, input int y2,
                         input bit typed, input int diff, input bit valid);
    date_word_t w;
    w.d1 = DAY_W'(d1);
    w.m1 = MONTH_W'(m1);
    w.y1 = YEAR_W'(y1);
    w.d2 = DAY_W'(d2);
    w.m2 = MONTH_W'(m2);
    w.y2 = YEAR_W'(y2);
    w.typed = typed;
    w.result.diff  = DIFF_W'(diff);
    w.result.valid = valid;
    directed_words.push_back(w);
  endtask

  // Presents a word and holds it until the block takes it. start_i is left
  // high, so a following word may go out at the very next edge.
  task automatic send_word(input date_word_t w);
    first_day_i    <= w.d1;
    first_month_i  <= w.m1;
    first_year_i   <= w.y1;
    second_day_i   <= w.d2;
    second_month_i <= w.m2;
    second_year_i  <= w.y2;
    word_typed_q   <= w.typed;
    word_result_q  <= w.result;
    start_i        <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Drops start_i for a random burst now and then, outside the tail.
  task automatic maybe_idle(input bit allowed);
    if (allowed && $urandom_range(0, 99) < 30) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Year near a boundary of the calendar rules or of the field.
  function automatic int unsigned edge_year();
    case ($urandom_range(0, 12))
      0:       return 1;
      1:       return 2;
      2:       return 4;
      3:       return 100;
      4:       return 400;
      5:       return 1600;
      6:       return 1900;
      7:       return 2000;
      8:       return 2100;
      9:       return 8192;
      10:      return 9998;
      11:      return MAX_YEAR;
      default: return 4 * $urandom_range(1, MAX_YEAR / 4);
    endcase
  endfunction

  // Draws one date. Most are well formed; some sit on month ends and leap
  // boundaries, some have one field broken, and a few are raw bits.
  task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                           output logic [YEAR_W-1:0] y);
    int unsigned dd;
    int unsigned mm;
    int unsigned yy;
    int unsigned sel;
    int unsigned len;
    sel = $urandom_range(0, 99);
    if (sel < 94) begin
      yy = (sel < 60) ? $urandom_range(1, MAX_YEAR) : edge_year();
      mm = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
      len = month_days(mm, yy);
      if (sel < 60) dd = $urandom_range(1, len);
      else dd = $urandom_range(0, 1) ? len : 1;
      // A share of the well-formed dates gets exactly one field broken.
      if (sel >= 82) begin
        case ($urandom_range(0, 2))
          0: dd = (len < 31 && $urandom_range(0, 1)) ? $urandom_range(len + 1, 31) : 0;
          1: mm = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
          default: yy = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_YEAR + 1, 16383);
        endcase
      end
      d = DAY_W'(dd);
      m = MONTH_W'(mm);
      y = YEAR_W'(yy);
    end else begin
      d = DAY_W'($urandom);
      m = MONTH_W'($urandom);
      y = YEAR_W'($urandom);
    end
  endtask

  initial begin
    date_word_t w;
    error_count    = 0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    first_day_i    <= '0;
    first_month_i  <= '0;
    first_year_i   <= '0;
    second_day_i   <= '0;
    second_month_i <= '0;
    second_year_i  <= '0;
    word_typed_q   <= 1'b0;
    word_result_q  <= '{diff: '0, valid: 1'b0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table: extremes, leap rule corners and every kind of bad date.
    add_row( 1,  1,     1,  1,  1,     1, 1,       0, 1);  // same date, start of calendar
    add_row( 1,  1,     1, 31, 12,  9999, 1, 3652058, 1);  // widest span
    add_row(31, 12,  9999,  1,  1,     1, 1, 3652058, 1);  // widest span, swapped
    add_row( 1,  1,     1,  2,  1,     1, 1,       1, 1);
    add_row(31, 12,  9999, 31, 12,  9999, 1,       0, 1);  // same date, end of calendar
    add_row( 1,  0,  2000,  1,  1,  2000, 1,       0, 0);  // month zero
    add_row( 1,  1,  2000,  5, 13,  2000, 1,       0, 0);  // month past December
    add_row(31, 15, 16383, 31, 15, 16383, 1,       0, 0);  // every bit set
    add_row( 0,  5,  1500,  1,  5,  1500, 1,       0, 0);  // day zero
    add_row( 1,  1,  2021, 31,  4,  2021, 1,       0, 0);  // day past a 30-day month
    add_row(29,  2,  1900,  1,  3,  1900, 1,       0, 0);  // century that is not leap
    add_row(29,  2,  2000,  1,  3,  2000, 1,       1, 1);  // century that is leap
    add_row(29,  2,  2004, 28,  2,  2004, 1,       1, 1);
    add_row(29,  2,  2001,  1,  1,  2001, 1,       0, 0);  // common year
    add_row( 1,  1,     0,  1,  1,     1, 1,       0, 0);  // year zero
    add_row( 1,  1,     1,  1,  1, 10000, 1,       0, 0);  // year past the limit
    add_row(31, 12,  1999,  1,  1,  2000, 1,       1, 1);
    add_row( 1,  1,  2000,  1,  1,  2001, 1,     366, 1);
    add_row( 1,  1,  1900,  1,  1,  1901, 1,     365, 1);
    add_row(31, 12,  2000,  1,  1,  2000, 1,     365, 1);
    add_row(28,  2,  2100,  1,  3,  2100, 1,       1, 1);
    add_row( 1,  3,  1600, 29,  2,  1600, 1,       1, 1);
    add_row(31,  7,  5000,  1,  8,  5000, 1,       1, 1);
    add_row(15,  6,  2345,  3, 11,  1234, 0,       0, 0);
    add_row(30,  1,  8192, 17,  9,  4095, 0,       0, 0);

    foreach (directed_words[i]) begin
      maybe_idle(1'b1);
      send_word(directed_words[i]);
    end

    // Random words; the last stretch runs back to back.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      maybe_idle(n < RANDOM_WORDS - TAIL_WORDS);
      pick_date(w.d1, w.m1, w.y1);
      pick_date(w.d2, w.m2, w.y2);
      w.typed  = 1'b0;
      w.result = '{diff: '0, valid: 1'b0};
      send_word(w);
    end
    start_i <= 1'b0;

    // Let the last word reach the monitor, drain the pipeline, then allow a
    // few more cycles for any stray strobe.
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
